### hdl/ptfc_pkg.sv
// Shared types and constants for the four-channel paddle timer.
// Used by ptfc_lane, ptfc_merge and paddle_timer_four_channel; no dependencies.
package ptfc_pkg;

    // Default build parameters
    localparam int DEF_NUM_PADDLES = 4;
    localparam int DEF_TIME_BITS   = 32;

    // Field widths
    localparam int POS_W      = 17;
    localparam int NOW_W      = 32;
    localparam int SEL_W      = 2;
    localparam int DATA_W     = 8;
    localparam int GAIN_W     = 12;
    localparam int TRIM_W     = 8;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Position sources: four real inputs, the rest read as zero
    localparam int NUM_INPUTS  = 4;
    localparam int SRC_SLOTS   = 8;
    localparam int SRC_IDX_W   = 3;

    // Arithmetic
    localparam int SCALE_SHIFT = 16;   // gain is unsigned 4.8, product drops 16 bits
    localparam int FRAC_W      = 8;    // delay factor is Q8.8
    localparam int COUNT_W     = 9;    // clamped count 0..280
    localparam int SUM_W       = 16;   // scaled count plus bias and trim
    localparam int PROD2_W     = COUNT_W + DELAY_W;

    localparam logic signed [SUM_W-1:0] COUNT_BIAS = 16'sd128;
    localparam logic signed [SUM_W-1:0] COUNT_HIGH = 16'sd255;
    localparam logic [COUNT_W-1:0]      COUNT_SAT  = 9'd280;

    // Commands
    localparam logic CMD_TRIGGER = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    // Read answers
    localparam logic [DATA_W-1:0] READ_BUSY = 8'h80;
    localparam logic [DATA_W-1:0] READ_IDLE = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_PAIRS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FACTOR = 3'd6;

    // Configuration reset values
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 12'd256;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd2826;

    // Per-lane stage enables from the sequencer
    typedef struct packed {
        logic scale_en;   // register position * gain
        logic delay_en;   // register clamped count * delay factor
        logic commit_en;  // write the new deadline
    } t_lane_ctl;

endpackage

### hdl/ptfc_lane.sv
// One paddle channel: invert, scale, trim, clamp and turn the count into a deadline.
// Depends on ptfc_pkg.
module ptfc_lane #(
    parameter int TIME_BITS = ptfc_pkg::DEF_TIME_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ptfc_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [ptfc_pkg::POS_W-1:0]     i_pos,
    input  logic                                  i_invert,
    input  logic [ptfc_pkg::GAIN_W-1:0]           i_gain,
    input  logic signed [ptfc_pkg::TRIM_W-1:0]    i_trim,
    input  logic [ptfc_pkg::DELAY_W-1:0]          i_delay,
    input  logic [TIME_BITS-1:0]                  i_now,
    output logic [TIME_BITS-1:0]                  o_deadline
);
    import ptfc_pkg::*;

    localparam int V_W   = POS_W + 1;
    localparam int P1_W  = V_W + GAIN_W + 1;
    localparam int Q_W   = P1_W - SCALE_SHIFT;
    localparam int DLY_W = PROD2_W - FRAC_W;
    localparam int ADD_W = (TIME_BITS > DLY_W) ? TIME_BITS : DLY_W;

    logic signed [V_W-1:0]    w_pos_ext;
    logic signed [V_W-1:0]    w_v;
    logic signed [GAIN_W:0]   w_gain_s;
    logic signed [P1_W-1:0]   r_prod1;
    logic signed [P1_W-1:0]   n_prod1;
    logic signed [Q_W-1:0]    w_q;
    logic signed [SUM_W-1:0]  w_sum;
    logic [COUNT_W-1:0]       w_count;
    logic [PROD2_W-1:0]       r_prod2;
    logic [PROD2_W-1:0]       n_prod2;
    logic [ADD_W-1:0]         w_add;
    logic [TIME_BITS-1:0]     r_deadline;

    // Negation of the most negative position needs the extra bit
    assign w_pos_ext = {i_pos[POS_W-1], i_pos};
    assign w_v       = i_invert ? -w_pos_ext : w_pos_ext;
    assign w_gain_s  = {1'b0, i_gain};
    assign n_prod1   = P1_W'(w_v) * P1_W'(w_gain_s);

    // Arithmetic shift by slicing: rounds toward minus infinity
    assign w_q   = r_prod1[P1_W-1:SCALE_SHIFT];
    assign w_sum = SUM_W'(w_q) + COUNT_BIAS + SUM_W'(i_trim);

    always_comb begin
        if (w_sum >= COUNT_HIGH) begin
            w_count = COUNT_SAT;
        end else if (w_sum < 0) begin
            w_count = '0;
        end else begin
            w_count = w_sum[COUNT_W-1:0];
        end
    end

    assign n_prod2 = PROD2_W'(w_count) * PROD2_W'(i_delay);
    assign w_add   = ADD_W'(i_now) + ADD_W'(r_prod2[PROD2_W-1:FRAC_W]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.scale_en) begin
            r_prod1 <= n_prod1;
        end
        if (i_ctl.delay_en) begin
            r_prod2 <= n_prod2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
        end else if (i_ctl.commit_en) begin
            r_deadline <= w_add[TIME_BITS-1:0];
        end
    end

    assign o_deadline = r_deadline;

endmodule

### hdl/ptfc_merge.sv
// Merge stage: pick the selected lane's deadline and test whether it is still ahead.
// Depends on ptfc_pkg.
module ptfc_merge #(
    parameter int NUM_PADDLES = ptfc_pkg::DEF_NUM_PADDLES,
    parameter int TIME_BITS   = ptfc_pkg::DEF_TIME_BITS
) (
    input  logic [NUM_PADDLES-1:0][TIME_BITS-1:0] i_deadlines,
    input  logic [ptfc_pkg::SEL_W-1:0]            i_sel,
    input  logic [TIME_BITS-1:0]                  i_now,
    output logic [ptfc_pkg::DATA_W-1:0]           o_read_data
);
    import ptfc_pkg::*;

    localparam int CMP_W = SRC_IDX_W + 1;

    logic                 w_hit;
    logic [TIME_BITS-1:0] w_pick;
    logic [TIME_BITS-1:0] w_diff;

    // Selects beyond the lane count match nothing and read as expired
    always_comb begin
        w_hit  = 1'b0;
        w_pick = '0;
        for (int k = 0; k < NUM_PADDLES; k++) begin
            if (CMP_W'(i_sel) == CMP_W'(k)) begin
                w_hit  = 1'b1;
                w_pick = i_deadlines[k];
            end
        end
    end

    assign w_diff = w_pick - i_now;

    always_comb begin
        if (w_hit && (w_diff != '0) && !w_diff[TIME_BITS-1]) begin
            o_read_data = READ_BUSY;
        end else begin
            o_read_data = READ_IDLE;
        end
    end

endmodule

### hdl/paddle_timer_four_channel.sv
// Four-channel game paddle timer, top level. Depends on ptfc_pkg, ptfc_lane, ptfc_merge.
// The input transfer registers position * gain, ST_SCALE the delay product, and
//   ST_DONE commits and loads the output register. A new item is taken only after
//   the last has finished; all lanes run their two registered multiplies side by side.
// Reset (synchronous, active low): deadlines clear to zero, configuration returns
//   to swap off, invert off, gains 1.0, trims 0, delay factor 2826; no output pending.
module paddle_timer_four_channel #(
    parameter int NUM_PADDLES = ptfc_pkg::DEF_NUM_PADDLES,
    parameter int TIME_BITS   = ptfc_pkg::DEF_TIME_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Item input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_command,
    input  logic [ptfc_pkg::NOW_W-1:0]            i_now,
    input  logic signed [ptfc_pkg::POS_W-1:0]     i_position_0,
    input  logic signed [ptfc_pkg::POS_W-1:0]     i_position_1,
    input  logic signed [ptfc_pkg::POS_W-1:0]     i_position_2,
    input  logic signed [ptfc_pkg::POS_W-1:0]     i_position_3,
    input  logic [ptfc_pkg::SEL_W-1:0]            i_paddle_sel,
    // Result output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ptfc_pkg::DATA_W-1:0]           o_read_data,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ptfc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ptfc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ptfc_pkg::*;

    localparam int NOW_EXT_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCALE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    // Configuration registers
    logic                       r_swap;
    logic                       r_invert;
    logic [GAIN_W-1:0]          r_gain_x;
    logic [GAIN_W-1:0]          r_gain_y;
    logic signed [TRIM_W-1:0]   r_offset_x;
    logic signed [TRIM_W-1:0]   r_offset_y;
    logic [DELAY_W-1:0]         r_delay;

    // Sequencer and captured item
    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic                       r_cmd;
    logic [SEL_W-1:0]           r_sel;
    logic [TIME_BITS-1:0]       r_now;
    logic                       r_out_valid;
    logic [DATA_W-1:0]          r_read_data;

    logic                       w_in_xfer;
    logic                       w_cfg_xfer;
    logic                       w_out_free;
    logic                       w_finish;
    logic [NOW_EXT_W-1:0]       w_now_ext;
    t_lane_ctl                  w_ctl;
    logic [DATA_W-1:0]          w_merge_data;

    logic signed [POS_W-1:0]                w_pos_src [SRC_SLOTS];
    logic [NUM_PADDLES-1:0][TIME_BITS-1:0]  w_deadlines;

    // ---------------------------------------------------------------
    // Configuration port: always ready, each write is registered directly.
    // Indexes past the register list are dropped.
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap     <= 1'b0;
            r_invert   <= 1'b0;
            r_gain_x   <= GAIN_RESET;
            r_gain_y   <= GAIN_RESET;
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_delay    <= DELAY_RESET;
        end else if (w_cfg_xfer) begin
            case (i_cfg_index)
                CFG_SWAP_PAIRS:   r_swap     <= i_cfg_data[0];
                CFG_INVERT:       r_invert   <= i_cfg_data[0];
                CFG_GAIN_X:       r_gain_x   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_Y:       r_gain_y   <= i_cfg_data[GAIN_W-1:0];
                CFG_OFFSET_X:     r_offset_x <= i_cfg_data[TRIM_W-1:0];
                CFG_OFFSET_Y:     r_offset_y <= i_cfg_data[TRIM_W-1:0];
                CFG_DELAY_FACTOR: r_delay    <= i_cfg_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: one item in flight. The lanes scale on the input
    // transfer, multiply by the delay factor in ST_SCALE and, for a trigger,
    // commit in ST_DONE as soon as the output register can take the result.
    // ---------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = (r_state == ST_DONE) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the item's command, select and timestamp for the later stages
    assign w_now_ext = NOW_EXT_W'(i_now);

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd <= i_command;
            r_sel <= i_paddle_sel;
            r_now <= w_now_ext[TIME_BITS-1:0];
        end
    end

    assign w_ctl.scale_en  = w_in_xfer;
    assign w_ctl.delay_en  = (r_state == ST_SCALE);
    assign w_ctl.commit_en = w_finish && (r_cmd == CMD_TRIGGER);

    // ---------------------------------------------------------------
    // Position sources: the four inputs, then zero for any channel
    // index past them (reachable through extra lanes, swap on or off).
    // ---------------------------------------------------------------
    assign w_pos_src[0] = i_position_0;
    assign w_pos_src[1] = i_position_1;
    assign w_pos_src[2] = i_position_2;
    assign w_pos_src[3] = i_position_3;

    generate
        for (genvar s = NUM_INPUTS; s < SRC_SLOTS; s++) begin : g_zero_src
            assign w_pos_src[s] = '0;
        end
    endgenerate

    // ---------------------------------------------------------------
    // Lanes: channel i reads source i, or i^1 with swap on. Gain and
    // trim follow the source's parity, not the channel's.
    // ---------------------------------------------------------------
    generate
        for (genvar i = 0; i < NUM_PADDLES; i++) begin : g_lane
            localparam logic [SRC_IDX_W-1:0] SRC_DIRECT  = SRC_IDX_W'(i);
            localparam logic [SRC_IDX_W-1:0] SRC_SWAPPED = SRC_IDX_W'(i ^ 1);
            localparam logic                 CH_ODD      = SRC_DIRECT[0];

            logic                     w_src_odd;
            logic signed [POS_W-1:0]  w_pos;
            logic [GAIN_W-1:0]        w_gain;
            logic signed [TRIM_W-1:0] w_trim;

            assign w_src_odd = CH_ODD ^ r_swap;
            assign w_pos     = r_swap ? w_pos_src[SRC_SWAPPED] : w_pos_src[SRC_DIRECT];
            assign w_gain    = w_src_odd ? r_gain_y : r_gain_x;
            assign w_trim    = w_src_odd ? r_offset_y : r_offset_x;

            ptfc_lane #(
                .TIME_BITS (TIME_BITS)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_pos      (w_pos),
                .i_invert   (r_invert),
                .i_gain     (w_gain),
                .i_trim     (w_trim),
                .i_delay    (r_delay),
                .i_now      (r_now),
                .o_deadline (w_deadlines[i])
            );
        end
    endgenerate

    // Merge: a read answers from the selected lane's deadline
    ptfc_merge #(
        .NUM_PADDLES (NUM_PADDLES),
        .TIME_BITS   (TIME_BITS)
    ) u_merge (
        .i_deadlines (w_deadlines),
        .i_sel       (r_sel),
        .i_now       (r_now),
        .o_read_data (w_merge_data)
    );

    // ---------------------------------------------------------------
    // Output register: load on finish, drop the valid once the result
    // transfers and nothing new replaces it. A trigger always reads 0.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_read_data <= (r_cmd == CMD_TRIGGER) ? READ_IDLE : w_merge_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

endmodule
